// ----- sv/token_pattern_matcher_top_defines.svh -----
// assertion macros shared by the matcher modules
`ifndef TOKEN_PATTERN_MATCHER_TOP_DEFINES_SVH
`define TOKEN_PATTERN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define TPM_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("matcher assertion failed");

// next-cycle implication
`define TPM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("matcher assertion failed");

`endif

// ----- sv/tpm_pkg.sv -----
package tpm_pkg;

   // pattern and window depth
   localparam int MAX_PATTERN = 64;
   localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int SUM_W       = LEN_W + 1;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int TOKEN_W  = 32;
   localparam int LINE_W   = 20;
   localparam int COL_W    = 16;
   localparam int WIN_W    = TOKEN_W + LINE_W + COL_W;

   // saturation limits
   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
   localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR    = 2'd0,
      OP_PATTERN  = 2'd1,
      OP_TEXT     = 2'd2,
      OP_LINE_END = 2'd3
   } opcode_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic compare_en;
      logic load_result;
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic scan_needed;
      logic hit;
      logic miss;
      logic out_free;
   } status_type;

endpackage

// ----- sv/tpm_req_if.sv -----
interface tpm_req_if;
   logic                         valid;
   logic                         ready;
   logic [tpm_pkg::OPCODE_W-1:0] opcode;
   logic [tpm_pkg::TOKEN_W-1:0]  token;

   modport source (output valid, output opcode, output token, input ready);
   modport sink   (input valid, input opcode, input token, output ready);
endinterface

// ----- sv/tpm_rsp_if.sv -----
interface tpm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tpm_pkg::LINE_W-1:0] match_line;
   logic [tpm_pkg::COL_W-1:0]  match_column;

   modport source (output valid, output match_line, output match_column, input ready);
   modport sink   (input valid, input match_line, input match_column, output ready);
endinterface

// ----- sv/tpm_ram.sv -----
module tpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/tpm_datapath.sv -----
`include "token_pattern_matcher_top_defines.svh"

module tpm_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  tpm_pkg::ctrl_type          ctrl_i,
   output tpm_pkg::status_type        status_o,
   input  logic [tpm_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [tpm_pkg::TOKEN_W-1:0]  req_token,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tpm_pkg::LINE_W-1:0] rsp_match_line,
   output logic [tpm_pkg::COL_W-1:0]  rsp_match_column
);
   import tpm_pkg::*;

   opcode_type op;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in, fill_next;
   logic [ADDR_W-1:0] head_ff, head_in, head_next;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [LEN_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [LINE_W-1:0] hit_line_ff, hit_line_in;
   logic [COL_W-1:0]  hit_col_ff, hit_col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0] rsp_line_ff, rsp_line_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;

   logic              issue_en;
   logic              pat_wr_en, win_wr_en;
   logic [SUM_W-1:0]  win_sum;
   logic [ADDR_W-1:0] win_rd_addr;
   logic [TOKEN_W-1:0] pat_q;
   logic [WIN_W-1:0]  win_q;
   logic [TOKEN_W-1:0] win_tok_q;
   logic [LINE_W-1:0] win_line_q;
   logic [COL_W-1:0]  win_col_q;
   logic              tok_eq, cmp_live;

   assign op = opcode_type'(req_opcode);

   // pattern and window memories
   assign pat_wr_en = ctrl_i.accept && (op == OP_PATTERN) && (len_ff < LEN_W'(MAX_PATTERN));
   assign win_wr_en = ctrl_i.accept && (op == OP_TEXT);

   tpm_ram #(.WIDTH(TOKEN_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_token),
      .rd_addr (issue_cnt_ff[ADDR_W-1:0]),
      .rd_data (pat_q)
   );

   tpm_ram #(.WIDTH(WIN_W), .DEPTH(MAX_PATTERN)) u_window_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (head_ff),
      .wr_data ({req_token, line_ff, col_ff}),
      .rd_addr (win_rd_addr),
      .rd_data (win_q)
   );

   assign {win_tok_q, win_line_q, win_col_q} = win_q;

   // window slot of pattern index: head - len + index, modulo depth
   always_comb begin
      win_sum = SUM_W'(head_ff) + SUM_W'(MAX_PATTERN) - SUM_W'(len_ff)
              + SUM_W'(issue_cnt_ff);
      if (win_sum >= SUM_W'(MAX_PATTERN)) begin
         win_sum = win_sum - SUM_W'(MAX_PATTERN);
      end
      win_rd_addr = win_sum[ADDR_W-1:0];
   end

   // saturating fill and wrapping head
   assign fill_next = (fill_ff == LEN_W'(MAX_PATTERN)) ? fill_ff : fill_ff + 1'b1;
   assign head_next = (head_ff == ADDR_W'(MAX_PATTERN - 1)) ? '0 : head_ff + 1'b1;

   // compare of one fetched pair
   assign tok_eq   = (pat_q == win_tok_q);
   assign cmp_live = ctrl_i.compare_en && rd_valid_ff;
   assign issue_en = ctrl_i.compare_en && (issue_cnt_ff < len_ff);

   assign status_o.scan_needed = (op == OP_TEXT) && (len_ff != '0) && (fill_next >= len_ff);
   assign status_o.hit  = cmp_live && tok_eq && (rd_idx_ff == LEN_W'(len_ff - 1'b1));
   assign status_o.miss = cmp_live && !tok_eq;
   assign status_o.out_free = !rsp_valid_ff || rsp_ready;

   // word execution and scan bookkeeping
   always_comb begin
      len_in       = len_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_valid_in  = issue_en;
      rd_idx_in    = issue_cnt_ff;
      hit_line_in  = hit_line_ff;
      hit_col_in   = hit_col_ff;
      if (ctrl_i.accept) begin
         issue_cnt_in = '0;
         unique case (op)
            OP_CLEAR: begin
               len_in  = '0;
               fill_in = '0;
               head_in = '0;
               line_in = '0;
               col_in  = '0;
            end
            OP_PATTERN: begin
               if (len_ff < LEN_W'(MAX_PATTERN)) begin
                  len_in = len_ff + 1'b1;
               end
            end
            OP_TEXT: begin
               fill_in = fill_next;
               head_in = head_next;
               if (col_ff != COL_MAX) begin
                  col_in = col_ff + 1'b1;
               end
            end
            OP_LINE_END: begin
               if (line_ff != LINE_MAX) begin
                  line_in = line_ff + 1'b1;
               end
               col_in = '0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end else if (issue_en) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end
      // first token of the occurrence carries the position
      if (cmp_live && (rd_idx_ff == '0)) begin
         hit_line_in = win_line_q;
         hit_col_in  = win_col_q;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_col_in   = rsp_col_ff;
      if (ctrl_i.load_result) begin
         rsp_valid_in = 1'b1;
         rsp_line_in  = hit_line_ff;
         rsp_col_in   = hit_col_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         line_ff      <= '0;
         col_ff       <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      hit_line_ff <= hit_line_in;
      hit_col_ff  <= hit_col_in;
      rsp_line_ff <= rsp_line_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_line   = rsp_line_ff;
   assign rsp_match_column = rsp_col_ff;

   // checks
   `TPM_ASSERT_IMPLY(a_hit_miss_excl, clock, reset, status_o.hit, !status_o.miss)
   `TPM_ASSERT_NEXT(a_load_sets_valid, clock, reset, ctrl_i.load_result, rsp_valid_ff)
   `TPM_ASSERT_IMPLY(a_fetch_in_range, clock, reset, cmp_live, rd_idx_ff < len_ff)
endmodule

// ----- sv/tpm_controller.sv -----
`include "token_pattern_matcher_top_defines.svh"

module tpm_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tpm_pkg::status_type status_i,
   output tpm_pkg::ctrl_type   ctrl_o
);
   import tpm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign ctrl_o.accept      = accept;
   assign ctrl_o.compare_en  = (state_ff == ST_SCAN);
   assign ctrl_o.load_result = (state_ff == ST_HOLD) && status_i.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status_i.scan_needed) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status_i.hit) begin
               state_in = ST_HOLD;
            end else if (status_i.miss) begin
               state_in = ST_IDLE;
            end
         end
         ST_HOLD: begin
            if (status_i.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `TPM_ASSERT_NEXT(a_scan_start, clock, reset, accept && status_i.scan_needed, state_ff == ST_SCAN)
   `TPM_ASSERT_NEXT(a_hit_to_hold, clock, reset, (state_ff == ST_SCAN) && status_i.hit, state_ff == ST_HOLD)
   `TPM_ASSERT_NEXT(a_hold_release, clock, reset, ctrl_o.load_result, state_ff == ST_IDLE)
endmodule

// ----- sv/token_pattern_matcher_top.sv -----
// clear, pattern, line-end and non-matching-length text words run without a scan
// a text word that triggers a scan goes through scan and, on a hit, hold to a result
// throughput: one pattern compare per cycle, set by the single read port of each ram
// a mismatch at any pattern index ends the scan with no result
// reset: synchronous, clears lengths, fill, head, line and column; rams keep contents
module token_pattern_matcher_top (
   input logic       clock,
   input logic       reset,
   tpm_req_if.sink   req_if,
   tpm_rsp_if.source rsp_if
);
   import tpm_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // sequencing
   tpm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status_i  (status),
      .ctrl_o    (ctrl)
   );

   // storage, counters and compare
   tpm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl_i           (ctrl),
      .status_o         (status),
      .req_opcode       (req_if.opcode),
      .req_token        (req_if.token),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_match_line   (rsp_if.match_line),
      .rsp_match_column (rsp_if.match_column)
   );
endmodule

// ----- test/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpm_pkg::*;

   localparam int RANDOM_WORDS = 1500;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int QUEUE_DEPTH  = 16;

   typedef struct packed {
      opcode_type          opcode;
      logic [TOKEN_W-1:0]  token;
   } word_type;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
   } match_type;

   logic clock;
   logic reset;
   bit   calm = 1'b0;
   int   failures = 0;
   int   words_queued = 0;
   int   cycle_count = 0;

   word_type  pending_words[$];
   match_type expected_matches[$];

   // predictor state: pattern, recent text history and position counters
   logic [TOKEN_W-1:0] pat_words [MAX_PATTERN];
   int                 pat_count = 0;
   logic [TOKEN_W-1:0] hist_token [MAX_PATTERN];
   logic [LINE_W-1:0]  hist_line [MAX_PATTERN];
   logic [COL_W-1:0]   hist_col [MAX_PATTERN];
   int                 hist_count = 0;
   int                 hist_next = 0;
   logic [LINE_W-1:0]  line_pos = '0;
   logic [COL_W-1:0]   col_pos = '0;

   tpm_req_if req_if ();
   tpm_rsp_if rsp_if ();

   token_pattern_matcher_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OP_CLEAR;
      req_if.token = '0;
      rsp_if.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      failures++;
   endtask

   // history slot holding the word of a given age, age 0 newest
   function automatic int slot_of_age(input int age);
      return (hist_next + MAX_PATTERN - 1 - age) % MAX_PATTERN;
   endfunction

   // advance the matcher state by one word, return 1 when it completes a match
   function automatic bit predict_match(input opcode_type op, input logic [TOKEN_W-1:0] tok,
                                        output match_type found);
      int  n;
      bit  hit;
      found = '0;
      case (op)
         OP_CLEAR: begin
            pat_count = 0;
            hist_count = 0;
            hist_next = 0;
            line_pos = '0;
            col_pos = '0;
            return 1'b0;
         end
         OP_PATTERN: begin
            if (pat_count < MAX_PATTERN) begin
               pat_words[pat_count] = tok;
               pat_count++;
            end
            return 1'b0;
         end
         OP_LINE_END: begin
            if (line_pos != LINE_MAX) line_pos++;
            col_pos = '0;
            return 1'b0;
         end
         default: begin
            hist_token[hist_next] = tok;
            hist_line[hist_next] = line_pos;
            hist_col[hist_next] = col_pos;
            hist_next = (hist_next + 1) % MAX_PATTERN;
            if (hist_count < MAX_PATTERN) hist_count++;
            if (col_pos != COL_MAX) col_pos++;
            n = pat_count;
            if (n == 0 || hist_count < n) return 1'b0;
            hit = 1'b1;
            for (int j = 0; j < n; j++) begin
               if (pat_words[j] != hist_token[slot_of_age(n - 1 - j)]) hit = 1'b0;
            end
            if (!hit) return 1'b0;
            found.line = hist_line[slot_of_age(n - 1)];
            found.column = hist_col[slot_of_age(n - 1)];
            return 1'b1;
         end
      endcase
   endfunction

   // driver: present queued words, predict each accepted one
   always @(posedge clock) begin
      word_type  next_w;
      match_type found;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (predict_match(opcode_type'(req_if.opcode), req_if.token, found))
               expected_matches = {expected_matches, found};
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
               next_w = pending_words.pop_front();
               req_if.valid <= 1'b1;
               req_if.opcode <= next_w.opcode;
               req_if.token <= next_w.token;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted match with the oldest prediction
   always @(posedge clock) begin
      match_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("unexpected match at line %0d column %0d",
                                         rsp_if.match_line, rsp_if.match_column));
            end else begin
               want = expected_matches.pop_front();
               if (rsp_if.match_line !== want.line)
                  report_mismatch($sformatf("match_line %0d, predicted %0d",
                                            rsp_if.match_line, want.line));
               if (rsp_if.match_column !== want.column)
                  report_mismatch($sformatf("match_column %0d, predicted %0d",
                                            rsp_if.match_column, want.column));
            end
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= 38);
      end
   end

   // hard stop on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic queue_word(input opcode_type op, input logic [TOKEN_W-1:0] tok);
      word_type w;
      while (pending_words.size() >= QUEUE_DEPTH) @(posedge clock);
      w.opcode = op;
      w.token = tok;
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   task automatic wait_queue_empty();
      while (pending_words.size() != 0 || req_if.valid) @(posedge clock);
   endtask

   // one random episode: mostly a loaded pattern and text with planted copies
   task automatic run_episode();
      logic [TOKEN_W-1:0] alphabet [3];
      logic [TOKEN_W-1:0] pat [$];
      logic [TOKEN_W-1:0] tok;
      int plen, nwords, k, r, span, cut;
      bit broken;
      if ($urandom_range(99) < 8) begin
         // noise: any opcode, any token
         repeat (30) queue_word(opcode_type'($urandom_range(int'(OP_LINE_END))), $urandom);
         return;
      end
      if ($urandom_range(3) != 0) queue_word(OP_CLEAR, $urandom);
      foreach (alphabet[i]) alphabet[i] = $urandom;
      r = $urandom_range(99);
      if (r < 5) plen = 0;
      else if (r < 10) plen = $urandom_range(60, 70);
      else plen = $urandom_range(1, 6);
      for (int i = 0; i < plen; i++) begin
         tok = alphabet[$urandom_range(2)];
         pat = {pat, tok};
         queue_word(OP_PATTERN, tok);
      end
      nwords = $urandom_range(20, 60);
      k = 0;
      while (k < nwords) begin
         r = $urandom_range(99);
         if (r < 35 && pat.size() != 0) begin
            // planted occurrence, sometimes with one token spoiled
            span = (pat.size() > MAX_PATTERN) ? MAX_PATTERN : pat.size();
            broken = ($urandom_range(4) == 0);
            cut = $urandom_range(span - 1);
            for (int i = 0; i < span; i++) begin
               tok = (broken && i == cut) ? $urandom : pat[i];
               queue_word(OP_TEXT, tok);
            end
            k += span;
         end else if (r < 45) begin
            queue_word(OP_LINE_END, $urandom);
            k++;
         end else if (r < 48) begin
            tok = alphabet[$urandom_range(2)];
            pat = {pat, tok};
            queue_word(OP_PATTERN, tok);
            k++;
         end else if (r < 52) begin
            queue_word(OP_TEXT, $urandom);
            k++;
         end else begin
            queue_word(OP_TEXT, alphabet[$urandom_range(2)]);
            k++;
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      int random_start;
      @(negedge reset);

      // directed: extreme tokens, line crossings, empty lines, late pattern, overlaps
      queue_word(OP_CLEAR, 32'hFFFFFFFF);
      queue_word(OP_TEXT, 32'h12345678);
      queue_word(OP_PATTERN, 32'h00000000);
      queue_word(OP_PATTERN, 32'hFFFFFFFF);
      queue_word(OP_TEXT, 32'h00000000);
      queue_word(OP_TEXT, 32'hFFFFFFFF);
      queue_word(OP_LINE_END, 32'h00000000);
      queue_word(OP_LINE_END, 32'h00000000);
      queue_word(OP_TEXT, 32'h00000000);
      queue_word(OP_LINE_END, 32'hFFFFFFFF);
      queue_word(OP_TEXT, 32'hFFFFFFFF);
      queue_word(OP_PATTERN, 32'h00000000);
      queue_word(OP_TEXT, 32'h00000000);
      queue_word(OP_CLEAR, 32'h00000000);
      queue_word(OP_PATTERN, 32'hA5A5A5A5);
      queue_word(OP_PATTERN, 32'hA5A5A5A5);
      repeat (3) queue_word(OP_TEXT, 32'hA5A5A5A5);
      queue_word(OP_TEXT, 32'h5A5A5A5A);
      repeat (2) queue_word(OP_TEXT, 32'hA5A5A5A5);

      // random episodes, one stretch without idling
      random_start = words_queued;
      while (words_queued - random_start < RANDOM_WORDS) begin
         calm <= (words_queued - random_start >= 600 && words_queued - random_start < 800);
         run_episode();
      end

      wait_queue_empty();
      calm <= 1'b1;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
